FILE: rtl/jst_pkg.sv
package jst_pkg;

	localparam int MAX_NEST = 64;
	localparam int NEST_AW  = $clog2(MAX_NEST);
	localparam int DEPTH_W  = 7;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam int ODEPTH = 2;
	localparam int OAW    = $clog2(ODEPTH);
	localparam int OCW    = $clog2(ODEPTH + 1);

	localparam logic [8:0] X_OBJ_START = 9'h100;
	localparam logic [8:0] X_ARR_START = 9'h080;
	localparam logic [8:0] X_OBJ_END   = 9'h040;
	localparam logic [8:0] X_ARR_END   = 9'h020;
	localparam logic [8:0] X_KEY       = 9'h010;
	localparam logic [8:0] X_COLON     = 9'h008;
	localparam logic [8:0] X_OBJ_VAL   = 9'h004;
	localparam logic [8:0] X_ARR_VAL   = 9'h002;
	localparam logic [8:0] X_NODE      = 9'h001;

	typedef enum logic [3:0] {
		EV_NONE,
		EV_OBJ_OPEN,
		EV_OBJ_CLOSE,
		EV_ARR_OPEN,
		EV_ARR_CLOSE,
		EV_KEY_BYTE,
		EV_KEY_END,
		EV_STR_BYTE,
		EV_STR_END,
		EV_NUM_BYTE,
		EV_TRUE,
		EV_FALSE,
		EV_NULL,
		EV_COLON,
		EV_COMMA
	} event_t;

	typedef enum logic [2:0] {
		ER_OK,
		ER_UNEXP,
		ER_ESC,
		ER_CTRL,
		ER_LIT,
		ER_OVF
	} err_t;

	typedef enum logic [2:0] {
		M_STRUCT,
		M_KEY,
		M_STR,
		M_NUM,
		M_LIT,
		M_HALT
	} mode_t;

	typedef enum logic [3:0] {
		CL_WS,
		CL_LBRACE,
		CL_RBRACE,
		CL_LBRACK,
		CL_RBRACK,
		CL_COLON,
		CL_COMMA,
		CL_QUOTE,
		CL_NUM,
		CL_LIT_T,
		CL_LIT_F,
		CL_LIT_N,
		CL_ZERO,
		CL_OTHER
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [7:0] ch;
		logic       numr;
		logic       ctrl;
		logic       bslash;
		logic       esc_ok;
		logic [7:0] esc_ch;
	} qitem_t;

	typedef struct packed {
		logic   valid;
		qitem_t item;
	} fq_t;

	typedef struct packed {
		event_t             ev;
		logic [7:0]         ch;
		logic               nend;
		logic [DEPTH_W-1:0] depth;
		err_t               err;
		logic               done;
	} result_t;

endpackage

FILE: rtl/json_stream_tokenizer_unit.sv
// channel  direction  handshake            payload
// input    in         push / full          byte_in
// result   out        empty / pop          event_res, byte_out, number_end, depth,
//                                          error, done_res
//
// one byte a cycle sustained while neither queue is full; a result enters the result queue as its byte is taken
// the nesting stack is a 64 x 1 memory with a registered read one level below the top
// asynchronous reset, no clearing pass; stack entries are written before they are read
// a four entry byte queue and a two entry result queue let each side stall on its own
module json_stream_tokenizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] byte_in,
	output logic       empty,
	input  logic       pop,
	output logic [3:0] event_res,
	output logic [7:0] byte_out,
	output logic       number_end,
	output logic [6:0] depth,
	output logic [2:0] error,
	output logic       done_res
);
	import jst_pkg::*;

	fq_t     fq;
	logic    take;
	logic    out_ready;
	result_t res;
	result_t head;

	jst_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.byte_in (byte_in),
		.take    (take),
		.fq      (fq)
	);

	jst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fq        (fq),
		.out_ready (out_ready),
		.take      (take),
		.res       (res)
	);

	jst_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (take),
		.wdata  (res),
		.ready  (out_ready),
		.pop    (pop),
		.empty  (empty),
		.rdata  (head)
	);

	assign event_res  = head.ev;
	assign byte_out   = head.ch;
	assign number_end = head.nend;
	assign depth      = head.depth;
	assign error      = head.err;
	assign done_res   = head.done;

endmodule

FILE: rtl/jst_front.sv
module jst_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [7:0]    byte_in,
	input  logic          take,
	output jst_pkg::fq_t  fq
);
	import jst_pkg::*;

	qitem_t         cl;
	qitem_t         mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [QCW-1:0] cnt_q;
	logic           wr;
	logic           rd;

	always_comb begin
		cl.ch     = byte_in;
		cl.numr   = (byte_in >= 8'h2D) && (byte_in <= 8'h3A);
		cl.ctrl   = byte_in < 8'h20;
		cl.bslash = byte_in == 8'h5C;
		case (byte_in) inside
			8'h20, 8'h09, 8'h0A, 8'h0D: cl.cls = CL_WS;
			8'h7B:                      cl.cls = CL_LBRACE;
			8'h7D:                      cl.cls = CL_RBRACE;
			8'h5B:                      cl.cls = CL_LBRACK;
			8'h5D:                      cl.cls = CL_RBRACK;
			8'h3A:                      cl.cls = CL_COLON;
			8'h2C:                      cl.cls = CL_COMMA;
			8'h22:                      cl.cls = CL_QUOTE;
			8'h2D, [8'h30:8'h39]:       cl.cls = CL_NUM;
			8'h74:                      cl.cls = CL_LIT_T;
			8'h66:                      cl.cls = CL_LIT_F;
			8'h6E:                      cl.cls = CL_LIT_N;
			8'h00:                      cl.cls = CL_ZERO;
			default:                    cl.cls = CL_OTHER;
		endcase
		cl.esc_ok = 1'b1;
		case (byte_in)
			8'h22:   cl.esc_ch = 8'h22;
			8'h5C:   cl.esc_ch = 8'h5C;
			8'h62:   cl.esc_ch = 8'h08;
			8'h66:   cl.esc_ch = 8'h0C;
			8'h6E:   cl.esc_ch = 8'h0A;
			8'h72:   cl.esc_ch = 8'h0D;
			8'h74:   cl.esc_ch = 8'h09;
			default: begin
				cl.esc_ch = 8'h00;
				cl.esc_ok = 1'b0;
			end
		endcase
	end

	assign full     = cnt_q == QCW'(QDEPTH);
	assign wr       = push && !full;
	assign rd       = take && fq.valid;
	assign fq.valid = cnt_q != '0;
	assign fq.item  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= cl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + QAW'(1);
			end
			if (rd) begin
				rptr_q <= rptr_q + QAW'(1);
			end
			cnt_q <= cnt_q + QCW'(wr) - QCW'(rd);
		end
	end

endmodule

FILE: rtl/jst_back.sv
module jst_back (
	input  logic             clk,
	input  logic             arst_n,
	input  jst_pkg::fq_t     fq,
	input  logic             out_ready,
	output logic             take,
	output jst_pkg::result_t res
);
	import jst_pkg::*;

	function automatic logic [2:0] lit_len(input logic [1:0] k);
		case (k)
			2'd1:    lit_len = 3'd5;
			default: lit_len = 3'd4;
		endcase
	endfunction

	function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] p);
		lit_char = 8'h00;
		case (k)
			2'd0: begin
				case (p)
					3'd0:    lit_char = 8'h74;
					3'd1:    lit_char = 8'h72;
					3'd2:    lit_char = 8'h75;
					3'd3:    lit_char = 8'h65;
					default: lit_char = 8'h00;
				endcase
			end
			2'd1: begin
				case (p)
					3'd0:    lit_char = 8'h66;
					3'd1:    lit_char = 8'h61;
					3'd2:    lit_char = 8'h6C;
					3'd3:    lit_char = 8'h73;
					3'd4:    lit_char = 8'h65;
					default: lit_char = 8'h00;
				endcase
			end
			default: begin
				case (p)
					3'd0:    lit_char = 8'h6E;
					3'd1:    lit_char = 8'h75;
					3'd2:    lit_char = 8'h6C;
					3'd3:    lit_char = 8'h6C;
					default: lit_char = 8'h00;
				endcase
			end
		endcase
	endfunction

	qitem_t             it;
	logic               step;

	mode_t              mode_q;
	mode_t              mode_n;
	logic [8:0]         mask_q;
	logic [8:0]         mask_n;
	logic [DEPTH_W-1:0] depth_q;
	logic [DEPTH_W-1:0] depth_n;
	logic               top_q;
	logic               top_n;
	logic               esc_q;
	logic               esc_n;
	logic [1:0]         lkind_q;
	logic [1:0]         lkind_n;
	logic [2:0]         lpos_q;
	logic [2:0]         lpos_n;
	logic               below_q;
	logic               stk_q [MAX_NEST];

	logic               push_w;
	logic               push_obj;
	logic               st_do;
	logic               lit_last;
	logic               is_key;
	logic [1:0]         kidx;
	logic [2:0]         llen;
	logic [7:0]         lch;
	logic [8:0]         after_val;
	logic [NEST_AW-1:0] rd_addr;

	event_t             ev;
	logic [7:0]         bout;
	logic               nend;
	err_t               err;
	logic               done;

	assign it   = fq.item;
	assign step = fq.valid && out_ready;
	assign take = step;

	// datapath and result
	always_comb begin
		ev       = EV_NONE;
		bout     = 8'h00;
		nend     = 1'b0;
		err      = ER_OK;
		done     = 1'b0;
		mask_n   = mask_q;
		depth_n  = depth_q;
		top_n    = top_q;
		esc_n    = esc_q;
		lkind_n  = lkind_q;
		lpos_n   = lpos_q;
		push_w   = 1'b0;
		push_obj = 1'b0;
		st_do    = 1'b0;
		lit_last = 1'b0;
		is_key   = mode_q == M_KEY;
		kidx     = (lkind_q == 2'd3) ? 2'd2 : lkind_q;
		llen     = lit_len(kidx);
		lch      = lit_char(kidx, lpos_q);
		after_val = ((mask_q & X_OBJ_VAL) != '0) ? (X_NODE | X_OBJ_END) : (X_NODE | X_ARR_END);
		if (step) begin
			case (mode_q)
				M_KEY, M_STR: begin
					if (esc_q) begin
						esc_n = 1'b0;
						if (it.esc_ok) begin
							ev   = is_key ? EV_KEY_BYTE : EV_STR_BYTE;
							bout = it.esc_ch;
						end else begin
							err = ER_ESC;
						end
					end else if (it.ctrl) begin
						err = ER_CTRL;
					end else if (it.bslash) begin
						esc_n = 1'b1;
					end else if (it.cls == CL_QUOTE) begin
						ev = is_key ? EV_KEY_END : EV_STR_END;
					end else begin
						ev   = is_key ? EV_KEY_BYTE : EV_STR_BYTE;
						bout = it.ch;
					end
				end
				M_LIT: begin
					if (lpos_q >= llen || it.ch != lch) begin
						err = ER_LIT;
					end else if (lpos_q + 3'd1 == llen) begin
						lit_last = 1'b1;
						lpos_n   = 3'd0;
						case (kidx)
							2'd0:    ev = EV_TRUE;
							2'd1:    ev = EV_FALSE;
							default: ev = EV_NULL;
						endcase
					end else begin
						lpos_n = lpos_q + 3'd1;
					end
				end
				M_NUM: begin
					if (it.numr) begin
						ev   = EV_NUM_BYTE;
						bout = it.ch;
					end else begin
						nend  = 1'b1;
						st_do = 1'b1;
					end
				end
				M_HALT: begin
				end
				default: st_do = 1'b1;
			endcase

			if (st_do) begin
				case (it.cls)
					CL_WS: begin
					end
					CL_LBRACE, CL_LBRACK: begin
						push_obj = it.cls == CL_LBRACE;
						if ((mask_q & (push_obj ? X_OBJ_START : X_ARR_START)) == '0) begin
							err = ER_UNEXP;
						end else if (depth_q >= DEPTH_W'(MAX_NEST)) begin
							err = ER_OVF;
						end else begin
							push_w  = 1'b1;
							top_n   = push_obj;
							depth_n = depth_q + DEPTH_W'(1);
							mask_n  = push_obj ? (X_OBJ_END | X_KEY)
								: (X_ARR_END | X_ARR_VAL | X_OBJ_START | X_ARR_START);
							ev      = push_obj ? EV_OBJ_OPEN : EV_ARR_OPEN;
						end
					end
					CL_RBRACE, CL_RBRACK: begin
						if ((mask_q & ((it.cls == CL_RBRACE) ? X_OBJ_END : X_ARR_END)) == '0
							|| depth_q == '0) begin
							err = ER_UNEXP;
						end else begin
							depth_n = depth_q - DEPTH_W'(1);
							top_n   = below_q;
							if (depth_q == DEPTH_W'(1)) begin
								mask_n = '0;
							end else begin
								mask_n = below_q ? (X_NODE | X_OBJ_END) : (X_NODE | X_ARR_END);
							end
							ev = (it.cls == CL_RBRACE) ? EV_OBJ_CLOSE : EV_ARR_CLOSE;
						end
					end
					CL_COLON: begin
						if ((mask_q & X_COLON) == '0) begin
							err = ER_UNEXP;
						end else begin
							mask_n = X_OBJ_VAL | X_OBJ_START | X_ARR_START;
							ev     = EV_COLON;
						end
					end
					CL_COMMA: begin
						if ((mask_q & X_NODE) == '0 || depth_q == '0) begin
							err = ER_UNEXP;
						end else begin
							mask_n = top_q ? X_KEY : (X_ARR_VAL | X_OBJ_START | X_ARR_START);
							ev     = EV_COMMA;
						end
					end
					CL_QUOTE: begin
						esc_n = 1'b0;
						if ((mask_q & (X_KEY | X_OBJ_VAL | X_ARR_VAL)) == '0) begin
							err = ER_UNEXP;
						end else if ((mask_q & X_KEY) != '0) begin
							mask_n = X_COLON;
						end else begin
							mask_n = after_val;
						end
					end
					CL_NUM: begin
						if ((mask_q & (X_OBJ_VAL | X_ARR_VAL)) == '0) begin
							err = ER_UNEXP;
						end else begin
							mask_n = after_val;
							ev     = EV_NUM_BYTE;
							bout   = it.ch;
						end
					end
					CL_LIT_T, CL_LIT_F, CL_LIT_N: begin
						if ((mask_q & (X_OBJ_VAL | X_ARR_VAL)) == '0) begin
							err = ER_UNEXP;
						end else begin
							mask_n = after_val;
							lpos_n = 3'd1;
							case (it.cls)
								CL_LIT_T: lkind_n = 2'd0;
								CL_LIT_F: lkind_n = 2'd1;
								default:  lkind_n = 2'd2;
							endcase
						end
					end
					CL_ZERO: begin
						if (mask_q == '0) begin
							done = 1'b1;
						end else begin
							err = ER_UNEXP;
						end
					end
					default: err = ER_UNEXP;
				endcase
			end

			if (err != ER_OK) begin
				ev   = EV_NONE;
				bout = 8'h00;
			end
		end
	end

	// next mode
	always_comb begin
		mode_n = mode_q;
		if (step) begin
			if (err != ER_OK) begin
				mode_n = M_HALT;
			end else begin
				case (mode_q)
					M_KEY, M_STR: begin
						if (!esc_q && it.cls == CL_QUOTE) begin
							mode_n = M_STRUCT;
						end
					end
					M_LIT: begin
						if (lit_last) begin
							mode_n = M_STRUCT;
						end
					end
					M_NUM, M_STRUCT: begin
						if (mode_q == M_NUM && it.numr) begin
							mode_n = M_NUM;
						end else begin
							case (it.cls)
								CL_QUOTE:                     mode_n = ((mask_q & X_KEY) != '0)
									? M_KEY : M_STR;
								CL_NUM:                       mode_n = M_NUM;
								CL_LIT_T, CL_LIT_F, CL_LIT_N: mode_n = M_LIT;
								CL_ZERO:                      mode_n = M_HALT;
								default:                      mode_n = M_STRUCT;
							endcase
						end
					end
					default: mode_n = mode_q;
				endcase
			end
		end
	end

	always_comb begin
		res.ev    = ev;
		res.ch    = bout;
		res.nend  = nend;
		res.depth = depth_n;
		res.err   = err;
		res.done  = done;
	end

	// entry below the top, read for the next depth
	assign rd_addr = NEST_AW'(depth_n - DEPTH_W'(2));

	always_ff @(posedge clk) begin
		if (push_w) begin
			stk_q[depth_q[NEST_AW-1:0]] <= push_obj;
		end
		below_q <= stk_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_STRUCT;
			mask_q  <= X_OBJ_START | X_ARR_START;
			depth_q <= '0;
			top_q   <= 1'b0;
			esc_q   <= 1'b0;
			lkind_q <= 2'd0;
			lpos_q  <= 3'd0;
		end else begin
			mode_q  <= mode_n;
			mask_q  <= mask_n;
			depth_q <= depth_n;
			top_q   <= top_n;
			esc_q   <= esc_n;
			lkind_q <= lkind_n;
			lpos_q  <= lpos_n;
		end
	end

endmodule

FILE: rtl/jst_outq.sv
module jst_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  jst_pkg::result_t wdata,
	output logic             ready,
	input  logic             pop,
	output logic             empty,
	output jst_pkg::result_t rdata
);
	import jst_pkg::*;

	result_t        mem_q [ODEPTH];
	logic [OAW-1:0] wptr_q;
	logic [OAW-1:0] rptr_q;
	logic [OCW-1:0] cnt_q;
	logic           rd;

	assign empty = cnt_q == '0;
	assign rd    = pop && !empty;
	assign ready = (cnt_q != OCW'(ODEPTH)) || rd;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + OAW'(1);
			end
			if (rd) begin
				rptr_q <= rptr_q + OAW'(1);
			end
			cnt_q <= cnt_q + OCW'(wr) - OCW'(rd);
		end
	end

endmodule

FILE: rtl/jst_checker.sv
module jst_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [3:0] event_res,
	input logic [7:0] byte_out,
	input logic [6:0] depth,
	input logic [2:0] error,
	input logic       done_res
);
	import jst_pkg::*;

	logic halt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halt_q <= 1'b0;
		end else if (pop && !empty && (error != ER_OK || done_res)) begin
			halt_q <= 1'b1;
		end
	end

	// once halted every later transaction is quiet
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && halt_q) |-> (event_res == EV_NONE && error == ER_OK && !done_res))
		else $error("result after halt is not quiet");

	a_err_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && error != ER_OK) |-> (event_res == EV_NONE && byte_out == 8'h00))
		else $error("error result carries an event");

	a_done_top: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && done_res) |-> (depth == '0 && error == ER_OK))
		else $error("document end inside a nesting level");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting result withdrawn");

endmodule

bind json_stream_tokenizer_unit jst_checker u_chk (.*);

FILE: bench/tb_json_stream_tokenizer_unit.sv
`timescale 1ns / 100ps

module tb_json_stream_tokenizer_unit;
	import jst_pkg::*;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;

	typedef enum int {
		END_DONE,
		END_EARLY_ZERO,
		END_STRAY,
		END_BAD_ESC,
		END_CTRL,
		END_LIT_BAD,
		END_OVERFLOW
	} doc_end_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] byte_in = 8'h00;
	logic       empty;
	logic       pop = 1'b0;
	logic [3:0] event_res;
	logic [7:0] byte_out;
	logic       number_end;
	logic [6:0] depth;
	logic [2:0] error;
	logic       done_res;

	json_stream_tokenizer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.byte_in(byte_in),
		.empty(empty),
		.pop(pop),
		.event_res(event_res),
		.byte_out(byte_out),
		.number_end(number_end),
		.depth(depth),
		.error(error),
		.done_res(done_res)
	);

	logic [7:0] text_q [$];
	result_t    predicted_tokens [$];
	int         bytes_taken = 0;
	int         results_seen = 0;
	int         fail_count = 0;
	int         mismatch_count = 0;

	string      lit_words [3] = '{"true", "false", "null"};
	logic [7:0] esc_codes [7] = '{"\"", "\\", "b", "f", "n", "r", "t"};
	logic [7:0] ws_codes [4] = '{" ", CH_TAB, CH_LF, CH_CR};

	// tokenizer state
	logic [8:0]          allowed;
	logic [MAX_NEST-1:0] nest_bits = '0;
	int                  nest_lvl = 0;
	mode_t               lex = M_STRUCT;
	logic                esc_pend = 1'b0;
	logic [1:0]          lit_kind = 2'd0;
	int                  lit_pos = 0;

	initial allowed = X_OBJ_START | X_ARR_START;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic tokenize(input logic [7:0] b, output result_t r);
		logic       run_struct;
		logic       is_obj;
		logic       is_key;
		logic [7:0] d;
		logic [8:0] val_bits;
		r = '0;
		run_struct = 1'b0;
		val_bits = X_OBJ_VAL | X_ARR_VAL;
		is_key = (lex == M_KEY);
		case (lex)
			M_HALT: ;
			M_KEY, M_STR: begin
				if (esc_pend) begin
					esc_pend = 1'b0;
					d = b;
					case (b)
						"\"", "\\": d = b;
						"b": d = CH_BS;
						"f": d = CH_FF;
						"n": d = CH_LF;
						"r": d = CH_CR;
						"t": d = CH_TAB;
						default: r.err = ER_ESC;
					endcase
					if (r.err == ER_OK) begin
						r.ev = is_key ? EV_KEY_BYTE : EV_STR_BYTE;
						r.ch = d;
					end
				end else if (b < 8'h20) begin
					r.err = ER_CTRL;
				end else if (b == "\\") begin
					esc_pend = 1'b1;
				end else if (b == "\"") begin
					r.ev = is_key ? EV_KEY_END : EV_STR_END;
					lex = M_STRUCT;
				end else begin
					r.ev = is_key ? EV_KEY_BYTE : EV_STR_BYTE;
					r.ch = b;
				end
			end
			M_LIT: begin
				if (lit_pos >= lit_words[lit_kind].len()
						|| b != lit_words[lit_kind][lit_pos]) begin
					r.err = ER_LIT;
				end else begin
					lit_pos++;
					if (lit_pos == lit_words[lit_kind].len()) begin
						case (lit_kind)
							2'd0: r.ev = EV_TRUE;
							2'd1: r.ev = EV_FALSE;
							default: r.ev = EV_NULL;
						endcase
						lex = M_STRUCT;
						lit_pos = 0;
					end
				end
			end
			M_NUM: begin
				if (b >= "-" && b <= ":") begin
					r.ev = EV_NUM_BYTE;
					r.ch = b;
				end else begin
					r.nend = 1'b1;
					lex = M_STRUCT;
					run_struct = 1'b1;
				end
			end
			default: begin
				lex = M_STRUCT;
				run_struct = 1'b1;
			end
		endcase

		if (run_struct) begin
			if (b == " " || b == CH_TAB || b == CH_LF || b == CH_CR) begin
			end else if (b == "{" || b == "[") begin
				is_obj = (b == "{");
				if (!(allowed & (is_obj ? X_OBJ_START : X_ARR_START))) begin
					r.err = ER_UNEXP;
				end else if (nest_lvl >= MAX_NEST) begin
					r.err = ER_OVF;
				end else begin
					nest_bits[nest_lvl] = is_obj;
					nest_lvl++;
					allowed = is_obj ? (X_OBJ_END | X_KEY)
						: (X_ARR_END | X_ARR_VAL | X_OBJ_START | X_ARR_START);
					r.ev = is_obj ? EV_OBJ_OPEN : EV_ARR_OPEN;
				end
			end else if (b == "}" || b == "]") begin
				is_obj = (b == "}");
				if (!(allowed & (is_obj ? X_OBJ_END : X_ARR_END)) || nest_lvl == 0) begin
					r.err = ER_UNEXP;
				end else begin
					nest_lvl--;
					if (nest_lvl == 0)
						allowed = '0;
					else
						allowed = nest_bits[nest_lvl-1] ? (X_NODE | X_OBJ_END)
							: (X_NODE | X_ARR_END);
					r.ev = is_obj ? EV_OBJ_CLOSE : EV_ARR_CLOSE;
				end
			end else if (b == ":") begin
				if (!(allowed & X_COLON)) begin
					r.err = ER_UNEXP;
				end else begin
					allowed = X_OBJ_VAL | X_OBJ_START | X_ARR_START;
					r.ev = EV_COLON;
				end
			end else if (b == ",") begin
				if (!(allowed & X_NODE) || nest_lvl == 0) begin
					r.err = ER_UNEXP;
				end else begin
					allowed = nest_bits[nest_lvl-1] ? X_KEY
						: (X_ARR_VAL | X_OBJ_START | X_ARR_START);
					r.ev = EV_COMMA;
				end
			end else if (b == "\"") begin
				if (!(allowed & (X_KEY | val_bits))) begin
					r.err = ER_UNEXP;
				end else if (allowed & X_KEY) begin
					lex = M_KEY;
					allowed = X_COLON;
				end else begin
					lex = M_STR;
					allowed = (allowed & X_OBJ_VAL) ? (X_NODE | X_OBJ_END)
						: (X_NODE | X_ARR_END);
				end
				esc_pend = 1'b0;
			end else if (b == "-" || (b >= "0" && b <= "9")) begin
				if (!(allowed & val_bits)) begin
					r.err = ER_UNEXP;
				end else begin
					allowed = (allowed & X_OBJ_VAL) ? (X_NODE | X_OBJ_END)
						: (X_NODE | X_ARR_END);
					lex = M_NUM;
					r.ev = EV_NUM_BYTE;
					r.ch = b;
				end
			end else if (b == "t" || b == "f" || b == "n") begin
				if (!(allowed & val_bits)) begin
					r.err = ER_UNEXP;
				end else begin
					allowed = (allowed & X_OBJ_VAL) ? (X_NODE | X_OBJ_END)
						: (X_NODE | X_ARR_END);
					lex = M_LIT;
					lit_kind = (b == "t") ? 2'd0 : (b == "f") ? 2'd1 : 2'd2;
					lit_pos = 1;
				end
			end else if (b == CH_NUL) begin
				if (allowed == '0) begin
					r.done = 1'b1;
					lex = M_HALT;
				end else begin
					r.err = ER_UNEXP;
				end
			end else begin
				r.err = ER_UNEXP;
			end
		end

		if (r.err != ER_OK) begin
			lex = M_HALT;
			r.ev = EV_NONE;
			r.ch = '0;
		end
		r.depth = 7'(nest_lvl);
	endtask

	function automatic int draw_gap(inout int calm);
		int roll;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 50)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 20);
	endfunction

	task automatic put(input logic [7:0] c);
		text_q.push_back(c);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	task automatic put_ws();
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 2))
				put(ws_codes[$urandom_range(0, 3)]);
	endtask

	task automatic put_string();
		int         roll;
		logic [7:0] c;
		put("\"");
		repeat ($urandom_range(0, 6)) begin
			roll = $urandom_range(0, 9);
			if (roll < 6) begin
				do
					c = 8'($urandom_range(8'h20, 8'h7E));
				while (c == "\"" || c == "\\");
				put(c);
			end else if (roll < 8) begin
				put(8'($urandom_range(8'h80, 8'hFF)));
			end else begin
				put("\\");
				put(esc_codes[$urandom_range(0, 6)]);
			end
		end
		put("\"");
	endtask

	task automatic put_value(input int level);
		int pick;
		int n;
		pick = $urandom_range(0, (level < 4) ? 9 : 5);
		if (pick < 2) begin
			put_string();
		end else if (pick < 4) begin
			put(($urandom_range(0, 10) == 10) ? 8'(45) : 8'($urandom_range(8'h30, 8'h39)));
			repeat ($urandom_range(0, 5))
				put(8'($urandom_range(8'h2D, 8'h3A)));
		end else if (pick < 6) begin
			put_text(lit_words[$urandom_range(0, 2)]);
		end else if (pick < 8) begin
			put("{");
			n = $urandom_range(0, 3);
			for (int i = 0; i < n; i++) begin
				put_ws();
				if (i > 0)
					put(",");
				put_ws();
				put_string();
				put_ws();
				put(":");
				put_ws();
				put_value(level + 1);
				put_ws();
			end
			put("}");
		end else begin
			put("[");
			n = $urandom_range(0, 3);
			for (int i = 0; i < n; i++) begin
				put_ws();
				if (i > 0)
					put(",");
				put_ws();
				put_value(level + 1);
				put_ws();
			end
			put("]");
		end
	endtask

	task automatic build_document();
		logic       deep_done;
		doc_end_t   ending;
		int         k;
		int         p;
		logic [7:0] c;
		logic       bad;
		deep_done = 1'b0;

		put_text("{\"");
		foreach (esc_codes[i]) begin
			put("\\");
			put(esc_codes[i]);
		end
		put("\"");
		put(CH_TAB);
		put_text(":[-9.:,true,false,null,{},[]]");

		while (text_q.size() < 600) begin
			put(",");
			put_ws();
			put_string();
			put_ws();
			put(":");
			put_ws();
			if (!deep_done && text_q.size() > 300) begin
				repeat (MAX_NEST - 1)
					put("[");
				put_value(4);
				repeat (MAX_NEST - 1)
					put("]");
				deep_done = 1'b1;
			end else begin
				put_value(1);
			end
			put_ws();
		end

		ending = doc_end_t'($urandom_range(0, 6));
		case (ending)
			END_DONE: begin
				put("}");
				put_ws();
				put(CH_NUL);
			end
			END_EARLY_ZERO: begin
				put(",");
				put_ws();
				put(CH_NUL);
			end
			END_STRAY: begin
				put("}");
				do
					c = 8'($urandom_range(1, 255));
				while (c == " " || c == CH_TAB || c == CH_LF || c == CH_CR);
				put(c);
			end
			END_BAD_ESC: begin
				put_text(",\"k");
				put("\\");
				do begin
					c = 8'($urandom_range(0, 255));
					bad = 1'b1;
					foreach (esc_codes[i])
						if (c == esc_codes[i])
							bad = 1'b0;
				end while (!bad);
				put(c);
			end
			END_CTRL: begin
				put_text(",\"k");
				put(8'($urandom_range(0, 31)));
			end
			END_LIT_BAD: begin
				put_text(",\"k\":");
				k = $urandom_range(0, 2);
				p = $urandom_range(1, lit_words[k].len() - 1);
				for (int i = 0; i < p; i++)
					put(lit_words[k][i]);
				do
					c = 8'($urandom_range(0, 255));
				while (c == lit_words[k][p]);
				put(c);
			end
			default: begin
				put_text(",\"k\":");
				repeat (MAX_NEST)
					put("[");
			end
		endcase

		// bytes after the block has stopped
		repeat ($urandom_range(4, 12))
			put(8'($urandom_range(0, 255)));
	endtask

	// sender
	int tx_seen = 0;
	int tx_gap = 0;
	int tx_calm = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (tx_seen != bytes_taken) begin
				tx_seen = bytes_taken;
				tx_gap = draw_gap(tx_calm);
			end
			if (tx_gap > 0) begin
				tx_gap--;
				push <= 1'b0;
			end else if (bytes_taken < text_q.size()) begin
				push <= 1'b1;
				byte_in <= text_q[bytes_taken];
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off to back the block up
	int rx_seen = 0;
	int rx_hold = 0;
	int rx_calm = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (rx_seen != results_seen) begin
				rx_seen = results_seen;
				rx_hold = (results_seen == 150) ? 80 : draw_gap(rx_calm);
			end
			if (rx_hold > 0) begin
				rx_hold--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// both transaction monitors
	always @(posedge clk) begin
		result_t want;
		if (arst_n && push && !full) begin
			tokenize(byte_in, want);
			predicted_tokens.push_back(want);
			bytes_taken++;
		end
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (predicted_tokens.size() == 0) begin
				fail_count++;
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result %0d arrived with none outstanding: ev %0d byte %h",
						results_seen, event_res, byte_out);
			end else begin
				want = predicted_tokens.pop_front();
				if (event_res !== want.ev || byte_out !== want.ch || number_end !== want.nend ||
						depth !== want.depth || error !== want.err || done_res !== want.done) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$write("result %0d: expected ev %0d byte %h nend %0d depth %0d ",
							results_seen, want.ev, want.ch, want.nend, want.depth);
						$write("err %0d done %0d, ", want.err, want.done);
						$write("got ev %0d byte %h nend %0d depth %0d ",
							event_res, byte_out, number_end, depth);
						$display("err %0d done %0d", error, done_res);
					end
				end
			end
		end
	end

	initial begin
		build_document();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		while (bytes_taken < text_q.size())
			@(posedge clk);
		while (predicted_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/jst_pkg.sv
rtl/jst_front.sv
rtl/jst_back.sv
rtl/jst_outq.sv
rtl/json_stream_tokenizer_unit.sv
rtl/jst_checker.sv
bench/tb_json_stream_tokenizer_unit.sv
